// ===== design/tovl_pkg.sv =====
// tovl_pkg: shared types and constants for the tracking overlay pixel block
// register map codes, overlay colors, glyph codes, 5x7 font table, status messages
// no dependencies
package tovl_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BLOB_LEFT   = 3'd0,
    REG_BLOB_RIGHT  = 3'd1,
    REG_BLOB_TOP    = 3'd2,
    REG_BLOB_BOTTOM = 3'd3,
    REG_OBJECT_COL  = 3'd4,
    REG_OBJECT_ROW  = 3'd5,
    REG_TARGET_SEEN = 3'd6,
    REG_BLOB_FOUND  = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    GLYPH_BLANK = 4'd0,
    GLYPH_D     = 4'd1,
    GLYPH_E     = 4'd2,
    GLYPH_T     = 4'd3,
    GLYPH_C     = 4'd4,
    GLYPH_N     = 4'd5,
    GLYPH_O     = 4'd6,
    GLYPH_A     = 4'd7,
    GLYPH_R     = 4'd8,
    GLYPH_G     = 4'd9
  } glyph_e;

  localparam rgb_t CENTER_CROSS_RGB = '{red: 8'd60,  green: 8'd160, blue: 8'd255};
  localparam rgb_t RING_RGB         = '{red: 8'd255, green: 8'd220, blue: 8'd40};
  localparam rgb_t OBJECT_CROSS_RGB = '{red: 8'd255, green: 8'd255, blue: 8'd255};
  localparam rgb_t TEXT_FOUND_RGB   = '{red: 8'd40,  green: 8'd255, blue: 8'd80};
  localparam rgb_t TEXT_LOST_RGB    = '{red: 8'd255, green: 8'd60,  blue: 8'd60};

  localparam int CENTER_CROSS_RAD = 9;
  localparam int OBJECT_CROSS_RAD = 8;
  localparam int RING_MARGIN      = 4;
  localparam int RING_MIN_RAD     = 2;
  localparam int RING_MIN_THICK   = 6;

  // status text: origin (8,8), scale 2, cells advance 12 pixels
  localparam int TEXT_X        = 8;
  localparam int TEXT_Y        = 8;
  localparam int TEXT_SCALE    = 2;
  localparam int CELL_ADVANCE  = 6 * TEXT_SCALE;
  localparam int GLYPH_COLS    = 5;
  localparam int GLYPH_ROWS    = 7;
  localparam int FOUND_LEN     = 8;
  localparam int LOST_LEN      = 9;
  localparam int TEXT_SPAN     = LOST_LEN * CELL_ADVANCE;
  localparam int TEXT_HEIGHT   = GLYPH_ROWS * TEXT_SCALE;
  // tx / 12 == (tx * 43) >> 9 for every tx below the text span
  localparam int CELL_RECIP    = 43;
  localparam int CELL_SHIFT    = 9;

  localparam logic [4:0] FONT_ROM [10][7] = '{
    '{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
    '{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
    '{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
    '{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
    '{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15}
  };

  localparam glyph_e MSG_FOUND [8] = '{
    GLYPH_D, GLYPH_E, GLYPH_T, GLYPH_E, GLYPH_C, GLYPH_T, GLYPH_E, GLYPH_D
  };

  localparam glyph_e MSG_LOST [9] = '{
    GLYPH_N, GLYPH_O, GLYPH_BLANK, GLYPH_T, GLYPH_A, GLYPH_R, GLYPH_G, GLYPH_E, GLYPH_T
  };

endpackage

// ===== design/tracking_overlay_pixel.sv =====
// tracking_overlay_pixel: per-pixel overlay of crosshairs, blob ring and status text
// depends on tovl_pkg (colors, register codes, font table)
//
// usage: pulse start with a pixel's column, row and rgb while busy is low; busy
// stays low, so a new item may be given in every cycle. the annotated rgb
// appears on out_*_o with result_valid_o high for exactly one cycle, once the
// item has passed through the input register and then the result register.
// throughput is one item per cycle: all overlay tests for a pixel run in
// parallel between those two registers, the widest path being the two
// distance squares of the ring test. the receiver cannot stall, so results are
// never held back.
// configuration goes through the apb port (register i at byte 4*i, no wait
// states); write it only while no item is in flight. ring center, radius,
// radius squared and thickness are recomputed from the registers every cycle
// into a geometry register that follows the configuration registers.
// reset clears all configuration registers to zero and drops any item in
// flight; no result strobe is given until a new item is taken.
module tracking_overlay_pixel #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  pixel_col_i,
  input  logic [8:0]  pixel_row_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  output logic        result_valid_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o
);
  import tovl_pkg::*;

  localparam int MaxDim0 = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
  localparam int MaxDim  = (MaxDim0 > 1024) ? MaxDim0 : 1024;
  localparam int CoordW  = $clog2(MaxDim) + 2;

  localparam logic signed [CoordW-1:0] CenterCol = CoordW'(FRAME_WIDTH / 2);
  localparam logic signed [CoordW-1:0] CenterRow = CoordW'(FRAME_HEIGHT / 2);
  localparam logic signed [CoordW-1:0] CcRad     = CoordW'(CENTER_CROSS_RAD);
  localparam logic [CoordW-1:0]        FrameW    = CoordW'(FRAME_WIDTH);
  localparam logic [CoordW-1:0]        FrameH    = CoordW'(FRAME_HEIGHT);

  // configuration registers
  logic [9:0] blob_left_q, blob_right_q, object_col_q;
  logic [8:0] blob_top_q, blob_bottom_q, object_row_q;
  logic       target_seen_q, blob_found_q;
  logic       cfg_wr;
  cfg_reg_e   cfg_sel;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_sel = cfg_reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blob_left_q   <= '0;
      blob_right_q  <= '0;
      blob_top_q    <= '0;
      blob_bottom_q <= '0;
      object_col_q  <= '0;
      object_row_q  <= '0;
      target_seen_q <= 1'b0;
      blob_found_q  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_BLOB_LEFT:   blob_left_q   <= pwdata[9:0];
        REG_BLOB_RIGHT:  blob_right_q  <= pwdata[9:0];
        REG_BLOB_TOP:    blob_top_q    <= pwdata[8:0];
        REG_BLOB_BOTTOM: blob_bottom_q <= pwdata[8:0];
        REG_OBJECT_COL:  object_col_q  <= pwdata[9:0];
        REG_OBJECT_ROW:  object_row_q  <= pwdata[8:0];
        REG_TARGET_SEEN: target_seen_q <= pwdata[0];
        REG_BLOB_FOUND:  blob_found_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_sel)
      REG_BLOB_LEFT:   prdata = {22'd0, blob_left_q};
      REG_BLOB_RIGHT:  prdata = {22'd0, blob_right_q};
      REG_BLOB_TOP:    prdata = {23'd0, blob_top_q};
      REG_BLOB_BOTTOM: prdata = {23'd0, blob_bottom_q};
      REG_OBJECT_COL:  prdata = {22'd0, object_col_q};
      REG_OBJECT_ROW:  prdata = {23'd0, object_row_q};
      REG_TARGET_SEEN: prdata = {31'd0, target_seen_q};
      REG_BLOB_FOUND:  prdata = {31'd0, blob_found_q};
      default:         prdata = '0;
    endcase
  end

  // ring geometry from the box registers
  logic [10:0]        sum_x;
  logic [9:0]         sum_y;
  logic signed [11:0] box_w, box_h, box_max, box_adj, half_max, rad_s;
  logic [9:0]         rad_u;
  logic [6:0]         rad_div8;
  logic [9:0]         ring_cx_d, ring_cx_q;
  logic [8:0]         ring_cy_d, ring_cy_q;
  logic               ring_en_d, ring_en_q;
  logic [19:0]        rad_sq_d, rad_sq_q;
  logic [10:0]        rad_lim_d, rad_lim_q;
  logic [6:0]         thick_d, thick_q;

  always_comb begin
    sum_x     = {1'b0, blob_left_q} + {1'b0, blob_right_q};
    sum_y     = {1'b0, blob_top_q} + {1'b0, blob_bottom_q};
    ring_cx_d = sum_x[10:1];
    ring_cy_d = sum_y[9:1];
    box_w     = $signed({2'b00, blob_right_q}) - $signed({2'b00, blob_left_q}) + 12'sd1;
    box_h     = $signed({3'b000, blob_bottom_q}) - $signed({3'b000, blob_top_q}) + 12'sd1;
    box_max   = (box_w > box_h) ? box_w : box_h;
    // halve rounding toward zero
    box_adj   = box_max + $signed({11'd0, box_max[11]});
    half_max  = box_adj >>> 1;
    rad_s     = half_max + 12'(RING_MARGIN);
    ring_en_d = rad_s >= 12'sd2;
    rad_u     = rad_s[9:0];
    rad_sq_d  = rad_u * rad_u;
    rad_lim_d = {1'b0, rad_u} + 11'd1;
    rad_div8  = rad_u[9:3];
    thick_d   = (rad_div8 > 7'(RING_MIN_THICK)) ? rad_div8 : 7'(RING_MIN_THICK);
  end

  always_ff @(posedge clk_i) begin
    ring_cx_q  <= ring_cx_d;
    ring_cy_q  <= ring_cy_d;
    ring_en_q  <= ring_en_d;
    rad_sq_q   <= rad_sq_d;
    rad_lim_q  <= rad_lim_d;
    thick_q    <= thick_d;
  end

  // input register
  logic       in_valid_q;
  logic [9:0] col_q;
  logic [8:0] row_q;
  rgb_t       pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      col_q <= pixel_col_i;
      row_q <= pixel_row_i;
      pix_q <= '{red: in_red_i, green: in_green_i, blue: in_blue_i};
    end
  end

  // frame bound and center crosshair
  logic signed [CoordW-1:0] pos_x, pos_y, cc_dx, cc_dy;
  logic                     in_frame, cc_hit;

  always_comb begin
    pos_x    = $signed({{(CoordW-10){1'b0}}, col_q});
    pos_y    = $signed({{(CoordW-9){1'b0}}, row_q});
    in_frame = ({{(CoordW-10){1'b0}}, col_q} < FrameW) &&
               ({{(CoordW-9){1'b0}}, row_q} < FrameH);
    cc_dx    = pos_x - CenterCol;
    cc_dy    = pos_y - CenterRow;
    cc_hit   = ((pos_y == CenterRow) && (cc_dx >= -CcRad) && (cc_dx <= CcRad)) ||
               ((pos_x == CenterCol) && (cc_dy >= -CcRad) && (cc_dy <= CcRad));
  end

  // ring test
  logic signed [10:0] rg_dx;
  logic signed [9:0]  rg_dy;
  logic [9:0]         abs_dx;
  logic [8:0]         abs_dy;
  logic [19:0]        sq_dx;
  logic [17:0]        sq_dy;
  logic [20:0]        dist_sq;
  logic signed [21:0] ring_err, thick_s;
  logic               ring_hit;

  always_comb begin
    rg_dx    = $signed({1'b0, col_q}) - $signed({1'b0, ring_cx_q});
    rg_dy    = $signed({1'b0, row_q}) - $signed({1'b0, ring_cy_q});
    abs_dx   = rg_dx[10] ? 10'(-rg_dx) : rg_dx[9:0];
    abs_dy   = rg_dy[9] ? 9'(-rg_dy) : rg_dy[8:0];
    sq_dx    = abs_dx * abs_dx;
    sq_dy    = abs_dy * abs_dy;
    dist_sq  = {1'b0, sq_dx} + {3'b000, sq_dy};
    ring_err = $signed({1'b0, dist_sq}) - $signed({2'b00, rad_sq_q});
    thick_s  = $signed({15'd0, thick_q});
    ring_hit = ring_en_q && ({1'b0, abs_dx} <= rad_lim_q) && ({2'b00, abs_dy} <= rad_lim_q) &&
               (ring_err <= thick_s) && (ring_err >= -thick_s);
  end

  // object crosshair
  logic signed [10:0] ob_dx;
  logic signed [9:0]  ob_dy;
  logic               obj_hit;

  always_comb begin
    ob_dx   = $signed({1'b0, col_q}) - $signed({1'b0, object_col_q});
    ob_dy   = $signed({1'b0, row_q}) - $signed({1'b0, object_row_q});
    obj_hit = ((row_q == object_row_q) && (ob_dx >= -11'(OBJECT_CROSS_RAD)) &&
               (ob_dx <= 11'(OBJECT_CROSS_RAD))) ||
              ((col_q == object_col_q) && (ob_dy >= -10'(OBJECT_CROSS_RAD)) &&
               (ob_dy <= 10'(OBJECT_CROSS_RAD)));
  end

  // status text
  logic [9:0]  tx;
  logic [8:0]  ty;
  logic [6:0]  tx_near;
  logic [12:0] cell_prod;
  logic [3:0]  cell_idx;
  logic [6:0]  cell_ofs;
  logic [2:0]  glyph_col, font_line;
  glyph_e      glyph;
  logic [4:0]  font_bits;
  logic        in_box, cell_ok, text_hit;

  always_comb begin
    tx        = col_q - 10'(TEXT_X);
    ty        = row_q - 9'(TEXT_Y);
    in_box    = (col_q >= 10'(TEXT_X)) && (tx < 10'(TEXT_SPAN)) &&
                (row_q >= 9'(TEXT_Y)) && (ty < 9'(TEXT_HEIGHT));
    tx_near   = tx[6:0];
    cell_prod = 13'(tx_near) * 13'(CELL_RECIP);
    cell_idx  = cell_prod[CELL_SHIFT+3:CELL_SHIFT];
    cell_ofs  = tx_near - 7'(cell_idx) * 7'(CELL_ADVANCE);
    glyph_col = cell_ofs[3:1];
    font_line = ty[3:1];
    cell_ok   = target_seen_q ? (cell_idx < 4'(FOUND_LEN)) : (cell_idx < 4'(LOST_LEN));
    glyph     = GLYPH_BLANK;
    if (cell_ok) begin
      glyph = target_seen_q ? MSG_FOUND[cell_idx[2:0]] : MSG_LOST[cell_idx];
    end
    font_bits = FONT_ROM[glyph][font_line];
    text_hit  = in_box && cell_ok && (glyph_col < 3'(GLYPH_COLS)) &&
                font_bits[3'd4 - glyph_col];
  end

  // layer priority: later layers win
  rgb_t paint_d, paint_q;
  logic out_valid_q;

  always_comb begin
    paint_d = pix_q;
    if (in_frame) begin
      if (cc_hit) begin
        paint_d = CENTER_CROSS_RGB;
      end
      if (target_seen_q && blob_found_q) begin
        if (ring_hit) begin
          paint_d = RING_RGB;
        end
        if (obj_hit) begin
          paint_d = OBJECT_CROSS_RGB;
        end
      end
      if (text_hit) begin
        paint_d = target_seen_q ? TEXT_FOUND_RGB : TEXT_LOST_RGB;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    paint_q <= paint_d;
  end

  assign result_valid_o = out_valid_q;
  assign out_red_o      = paint_q.red;
  assign out_green_o    = paint_q.green;
  assign out_blue_o     = paint_q.blue;

  // every registered item gives exactly one result strobe on the next edge
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |=> result_valid_o)
    else $error("registered item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |=> !result_valid_o)
    else $error("result strobe without an item");

  // with no layer active the source color passes through untouched
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && (!in_frame || (!cc_hit && !text_hit &&
      !(target_seen_q && blob_found_q)))) |=>
    (out_red_o == $past(pix_q.red) && out_green_o == $past(pix_q.green) &&
     out_blue_o == $past(pix_q.blue)))
    else $error("pixel altered with no overlay layer active");

endmodule

// ===== tb/sv/tb_tracking_overlay_pixel.sv =====
`timescale 1ns / 1ps
// tb_tracking_overlay_pixel: self-checking testbench for the per-pixel overlay block
// drives pixels on the start/busy port, programs the box over apb and checks each
// annotated pixel against an in-bench overlay predictor; depends on tovl_pkg
module tb_tracking_overlay_pixel;

  localparam int FRAME_W   = 640;
  localparam int FRAME_H   = 480;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  localparam color_t CROSS_COLOR  = {8'd60, 8'd160, 8'd255};
  localparam color_t RING_COLOR   = {8'd255, 8'd220, 8'd40};
  localparam color_t OBJECT_COLOR = {8'd255, 8'd255, 8'd255};
  localparam color_t FOUND_COLOR  = {8'd40, 8'd255, 8'd80};
  localparam color_t LOST_COLOR   = {8'd255, 8'd60, 8'd60};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [9:0]  pixel_col_i = '0;
  logic [8:0]  pixel_row_i = '0;
  logic [7:0]  in_red_i = '0;
  logic [7:0]  in_green_i = '0;
  logic [7:0]  in_blue_i = '0;
  logic        result_valid_o;
  logic [7:0]  out_red_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_blue_o;

  // copy of the register file as the block should hold it
  logic [9:0] box_left = '0, box_right = '0, obj_col = '0;
  logic [8:0] box_top = '0, box_bottom = '0, obj_row = '0;
  logic       seen = 1'b0, found = 1'b0;

  color_t pending_pixels[$];
  int     mismatch_count = 0;
  bit     steady = 1'b0;

  tracking_overlay_pixel u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .pixel_col_i    (pixel_col_i),
    .pixel_row_i    (pixel_row_i),
    .in_red_i       (in_red_i),
    .in_green_i     (in_green_i),
    .in_blue_i      (in_blue_i),
    .result_valid_o (result_valid_o),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int abs_int(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit on_cross(int x, int y, int cx, int cy, int rad);
    return (y == cy && abs_int(x - cx) <= rad) || (x == cx && abs_int(y - cy) <= rad);
  endfunction

  // signed on purpose: swapped bounds give a small or negative radius
  function automatic int ring_radius();
    int w, h;
    w = int'(box_right) - int'(box_left) + 1;
    h = int'(box_bottom) - int'(box_top) + 1;
    return (w > h ? w : h) / 2 + 4;
  endfunction

  function automatic bit on_ring(int x, int y);
    int r, thick, dx, dy;
    r = ring_radius();
    if (r < 2) return 1'b0;
    thick = (r / 8 > 6) ? r / 8 : 6;
    dx = x - (int'(box_left) + int'(box_right)) / 2;
    dy = y - (int'(box_top) + int'(box_bottom)) / 2;
    if (abs_int(dx) > r + 1 || abs_int(dy) > r + 1) return 1'b0;
    return abs_int(dx * dx + dy * dy - r * r) <= thick;
  endfunction

  function automatic tovl_pkg::glyph_e status_glyph(bit detected, int slot);
    if (detected) begin
      case (slot)
        1, 3, 6: return tovl_pkg::GLYPH_E;
        2, 5:    return tovl_pkg::GLYPH_T;
        4:       return tovl_pkg::GLYPH_C;
        default: return tovl_pkg::GLYPH_D;
      endcase
    end
    case (slot)
      0:       return tovl_pkg::GLYPH_N;
      1:       return tovl_pkg::GLYPH_O;
      2:       return tovl_pkg::GLYPH_BLANK;
      4:       return tovl_pkg::GLYPH_A;
      5:       return tovl_pkg::GLYPH_R;
      6:       return tovl_pkg::GLYPH_G;
      7:       return tovl_pkg::GLYPH_E;
      default: return tovl_pkg::GLYPH_T;
    endcase
  endfunction

  // 5x7 font, top row in the high bits, leftmost column in bit 4 of a row
  function automatic logic [4:0] font_row(tovl_pkg::glyph_e g, int row);
    logic [34:0] rows;
    case (g)
      tovl_pkg::GLYPH_D: rows = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      tovl_pkg::GLYPH_E: rows = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      tovl_pkg::GLYPH_T: rows = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      tovl_pkg::GLYPH_C: rows = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      tovl_pkg::GLYPH_N: rows = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      tovl_pkg::GLYPH_O: rows = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      tovl_pkg::GLYPH_A: rows = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      tovl_pkg::GLYPH_R: rows = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      tovl_pkg::GLYPH_G: rows = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      default:           rows = '0;
    endcase
    return rows[34 - 5 * row -: 5];
  endfunction

  // text at (8,8), scale 2, glyph slots 12 pixels apart
  function automatic bit on_text(int x, int y, bit detected);
    int tx, ty, slot, offset, col;
    logic [4:0] bits;
    tx = x - 8;
    ty = y - 8;
    if (tx < 0 || ty < 0 || ty >= 14) return 1'b0;
    slot = tx / 12;
    if (slot >= (detected ? 8 : 9)) return 1'b0;
    offset = tx % 12;
    col = offset / 2;
    if (col >= 5) return 1'b0;
    bits = font_row(status_glyph(detected, slot), ty / 2);
    return bits[4 - col];
  endfunction

  function automatic color_t predict_overlay(int x, int y, color_t src);
    color_t c;
    c = src;
    if (x < FRAME_W && y < FRAME_H) begin
      if (on_cross(x, y, FRAME_W / 2, FRAME_H / 2, 9)) c = CROSS_COLOR;
      if (seen && found) begin
        if (on_ring(x, y)) c = RING_COLOR;
        if (on_cross(x, y, int'(obj_col), int'(obj_row), 8)) c = OBJECT_COLOR;
      end
      if (on_text(x, y, seen)) c = seen ? FOUND_COLOR : LOST_COLOR;
    end
    return c;
  endfunction

  // ------------------------------------------------------------------ drivers

  function automatic int pick_gap();
    int p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic color_t random_color();
    return {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
            8'($urandom_range(0, 255))};
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send_pixel(int col, int row, color_t src);
    int gap;
    logic [9:0] c;
    logic [8:0] r;
    gap = pick_gap();
    c = col[9:0];
    r = row[8:0];
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    pixel_col_i <= c;
    pixel_row_i <= r;
    in_red_i    <= src.red;
    in_green_i  <= src.green;
    in_blue_i   <= src.blue;
    do @(posedge clk_i); while (busy);
    pending_pixels.push_back(predict_overlay(int'(c), int'(r), src));
  endtask

  task automatic wait_results();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // leaves psel high; apply_setting closes the transfer sequence
  task automatic write_reg(tovl_pkg::cfg_reg_e idx, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      tovl_pkg::REG_BLOB_LEFT:   box_left   = value[9:0];
      tovl_pkg::REG_BLOB_RIGHT:  box_right  = value[9:0];
      tovl_pkg::REG_BLOB_TOP:    box_top    = value[8:0];
      tovl_pkg::REG_BLOB_BOTTOM: box_bottom = value[8:0];
      tovl_pkg::REG_OBJECT_COL:  obj_col    = value[9:0];
      tovl_pkg::REG_OBJECT_ROW:  obj_row    = value[8:0];
      tovl_pkg::REG_TARGET_SEEN: seen       = value[0];
      default:                   found      = value[0];
    endcase
  endtask

  task automatic apply_setting(int unsigned l, int unsigned rt, int unsigned t,
                               int unsigned b, int unsigned oc, int unsigned orow,
                               int unsigned s, int unsigned f);
    wait_results();
    write_reg(tovl_pkg::REG_BLOB_LEFT, l);
    write_reg(tovl_pkg::REG_BLOB_RIGHT, rt);
    write_reg(tovl_pkg::REG_BLOB_TOP, t);
    write_reg(tovl_pkg::REG_BLOB_BOTTOM, b);
    write_reg(tovl_pkg::REG_OBJECT_COL, oc);
    write_reg(tovl_pkg::REG_OBJECT_ROW, orow);
    write_reg(tovl_pkg::REG_TARGET_SEEN, s);
    write_reg(tovl_pkg::REG_BLOB_FOUND, f);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ------------------------------------------------------------------ checker

  always @(posedge clk_i) begin : check_results
    color_t got, want;
    if (rst_ni && result_valid_o) begin
      got = {out_red_o, out_green_o, out_blue_o};
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("%0t: pixel out with none pending: rgb %0d %0d %0d",
                   $realtime, got.red, got.green, got.blue);
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("%0t: pixel mismatch: expected rgb %0d %0d %0d, got %0d %0d %0d",
                     $realtime, want.red, want.green, want.blue,
                     got.red, got.green, got.blue);
        end
      end
    end
  end

  // -------------------------------------------------------------------- tests

  // registers at reset: no target, so NO TARGET text and no ring
  task automatic test_reset_state();
    send_pixel(0, 0, {8'd0, 8'd0, 8'd0});
    send_pixel(639, 479, {8'd255, 8'd255, 8'd255});
    send_pixel(320, 240, random_color());
    send_pixel(329, 240, random_color());
    send_pixel(330, 240, random_color());
    send_pixel(320, 249, random_color());
    send_pixel(320, 250, random_color());
    send_pixel(8, 8, random_color());
    send_pixel(10, 8, random_color());
    send_pixel(18, 8, random_color());
    send_pixel(104, 21, random_color());
    send_pixel(116, 8, random_color());
    send_pixel(8, 22, random_color());
    // outside the frame the source color passes untouched
    send_pixel(640, 0, random_color());
    send_pixel(1023, 511, {8'd255, 8'd0, 8'd255});
    send_pixel(0, 480, {8'd0, 8'd255, 8'd0});
  endtask

  task automatic test_detected_overlay();
    // box centre (320,230), radius 34
    apply_setting(300, 340, 200, 260, 100, 100, 1, 1);
    send_pixel(354, 230, random_color());
    send_pixel(320, 264, random_color());
    send_pixel(355, 230, random_color());
    send_pixel(100, 100, random_color());
    send_pixel(108, 100, random_color());
    send_pixel(109, 100, random_color());
    send_pixel(8, 8, random_color());
  endtask

  // swapped bounds give a negative radius: no ring at all
  task automatic test_swapped_box();
    apply_setting(600, 10, 400, 5, 320, 240, 1, 1);
    send_pixel(320, 240, random_color());
    send_pixel(305, 202, random_color());
  endtask

  task automatic pick_setting(int phase);
    int w, h, l, rt, t, b, oc, orow, kind;
    kind = $urandom_range(0, 99);
    if (phase == 0) begin
      apply_setting(639, 639, 479, 479, 639, 479, 1, 1);
    end else if (phase == 1) begin
      apply_setting(0, 0, 0, 0, 0, 0, 1, 1);
    end else if (phase == 2) begin
      // whole-frame box: thick ring
      apply_setting(0, 639, 0, 479, 320, 240, 1, 1);
    end else if (kind < 70) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 640) : $urandom_range(1, 80);
      h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 480) : $urandom_range(1, 60);
      l = $urandom_range(0, 640 - w);
      t = $urandom_range(0, 480 - h);
      rt = l + w - 1;
      b = t + h - 1;
      oc = $urandom_range(l, rt);
      orow = $urandom_range(t, b);
      apply_setting(l, rt, t, b, oc, orow, $urandom_range(0, 9) < 7,
                    $urandom_range(0, 9) < 7);
    end else if (kind < 85) begin
      rt = $urandom_range(0, 600);
      l = $urandom_range(rt + 1, 639);
      b = $urandom_range(0, 440);
      t = $urandom_range(b + 1, 479);
      apply_setting(l, rt, t, b, $urandom_range(0, 639), $urandom_range(0, 479),
                    $urandom_range(0, 9) < 7, $urandom_range(0, 9) < 7);
    end else begin
      apply_setting($urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 511), $urandom_range(0, 511),
                    $urandom_range(0, 1023), $urandom_range(0, 511),
                    $urandom_range(0, 1), $urandom_range(0, 1));
    end
  endtask

  // bias pixels toward the features that the current setting draws
  task automatic send_random_pixel();
    int p, r, dx, dy, rem, col, row;
    p = $urandom_range(0, 99);
    r = ring_radius();
    if (p < 30 && seen && found && r >= 2) begin
      dx = $urandom_range(0, r + 1);
      rem = r * r - dx * dx;
      dy = 0;
      while ((dy + 1) * (dy + 1) <= rem) dy++;
      dy = dy + jitter(2);
      col = (int'(box_left) + int'(box_right)) / 2 + ($urandom_range(0, 1) ? dx : -dx);
      row = (int'(box_top) + int'(box_bottom)) / 2 + ($urandom_range(0, 1) ? dy : -dy);
    end else if (p < 45) begin
      if ($urandom_range(0, 1)) begin
        col = int'(obj_col) + jitter(10);
        row = int'(obj_row) + jitter(1);
      end else begin
        col = int'(obj_col) + jitter(1);
        row = int'(obj_row) + jitter(10);
      end
    end else if (p < 57) begin
      col = FRAME_W / 2 + jitter(11);
      row = FRAME_H / 2 + jitter(1);
      if ($urandom_range(0, 1)) begin
        col = FRAME_W / 2 + jitter(1);
        row = FRAME_H / 2 + jitter(11);
      end
    end else if (p < 72) begin
      col = $urandom_range(0, 130);
      row = $urandom_range(4, 25);
    end else if (p < 80) begin
      col = $urandom_range(0, 1023);
      row = $urandom_range(0, 511);
    end else begin
      col = $urandom_range(0, FRAME_W - 1);
      row = $urandom_range(0, FRAME_H - 1);
    end
    send_pixel(col, row, random_color());
  endtask

  task automatic test_random_frames();
    for (int phase = 0; phase < 20; phase++) begin
      pick_setting(phase);
      // every fourth phase runs back to back
      steady = (phase % 4 == 3);
      for (int n = 0; n < 32; n++) send_random_pixel();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_detected_overlay();
    test_swapped_box();
    test_random_frames();
    wait_results();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== tracking_overlay_pixel.f =====
design/tovl_pkg.sv
design/tracking_overlay_pixel.sv
tb/sv/tb_tracking_overlay_pixel.sv
